/* rtl/artl_pkg.sv */
// ----------------------------------------------------------------------------
// artl_pkg: shared types and constants of the rate-limited tracker
// Field widths, register indexes, register reset values and the register
// bundle that the configuration block hands to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package artl_pkg;

  // Field widths (fixed by the item format).
  localparam int VAL_W    = 32;  // signed Q16.16 values and velocity
  localparam int TIME_W   = 20;  // unsigned elapsed time
  localparam int DIST_W   = 31;  // unsigned limits and distances
  localparam int GAIN_W   = 24;  // unsigned approach gain
  localparam int PROD_W   = VAL_W + GAIN_W;
  localparam int CFG_IDX_W = 3;

  // Register indexes on the configuration channel.
  localparam logic [CFG_IDX_W-1:0] REG_MIN_TARGET    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_TARGET    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_SPEED    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_DISTANCE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SLOW_DISTANCE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_APPROACH_GAIN = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_FORCE     = 3'd6;

  // Register reset values.
  localparam logic [VAL_W-1:0]  RST_MIN_TARGET    = 32'd65536;
  localparam logic [VAL_W-1:0]  RST_MAX_TARGET    = 32'd6553600;
  localparam logic [DIST_W-1:0] RST_STOP_SPEED    = 31'd6554;
  localparam logic [DIST_W-1:0] RST_STOP_DISTANCE = 31'd6554;
  localparam logic [DIST_W-1:0] RST_SLOW_DISTANCE = 31'd655360;
  localparam logic [GAIN_W-1:0] RST_APPROACH_GAIN = 24'd65536;
  localparam logic [DIST_W-1:0] RST_MAX_FORCE     = 31'd65536;

  typedef struct packed {
    logic signed [VAL_W-1:0] min_target;
    logic signed [VAL_W-1:0] max_target;
    logic [DIST_W-1:0]       stop_speed;
    logic [DIST_W-1:0]       stop_distance;
    logic [DIST_W-1:0]       slow_distance;
    logic [GAIN_W-1:0]       approach_gain;
    logic [DIST_W-1:0]       max_force;
  } cfg_t;

endpackage

`default_nettype wire

/* rtl/artl_if.sv */
// ----------------------------------------------------------------------------
// artl_if: channel interfaces of the rate-limited tracker
// Input item channel, result channel and configuration write channel, each
// with valid/ready and a source and a sink modport.
// ----------------------------------------------------------------------------
`default_nettype none

interface artl_in_if import artl_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [VAL_W-1:0]  current_value;
  logic signed [VAL_W-1:0]  target_value;
  logic [TIME_W-1:0]        elapsed_time;

  modport source (output valid, current_value, target_value, elapsed_time,
                  input ready);
  modport sink (input valid, current_value, target_value, elapsed_time,
                output ready);
endinterface

interface artl_out_if import artl_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [VAL_W-1:0]  new_value;
  logic                     stopped;

  modport source (output valid, new_value, stopped, input ready);
  modport sink (input valid, new_value, stopped, output ready);
endinterface

interface artl_cfg_if import artl_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [VAL_W-1:0]      data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* rtl/arrive_rate_limited_tracker.sv */
// ----------------------------------------------------------------------------
// arrive_rate_limited_tracker: arrive-style rate-limited value tracker
// Moves a value toward a clamped target with a velocity whose change per
// step is limited, and stops when both speed and distance are small.
// ----------------------------------------------------------------------------
// Usage:
// The input channel in_i carries one step (current value, target, elapsed
// time); every transfer on it yields exactly one transfer on out_o with the
// new value and the stopped flag. Registers are written through cfg_i,
// which is always ready; write them only while no step is in flight.
// A step is worked by a sequencer around one bit-serial multiplier. The two
// products (distance times gain, velocity times time) are formed one
// multiplier bit per cycle, and the compares and adds around them each take
// a sequencer state of their own. The result is offered sooner when the stop
// rule fires, since both products are then skipped. A new step is taken only
// once the sequencer is back in idle, so steps do not overlap.
// The result sits in an output register; a new step is taken while it waits
// there, but that step holds before its own result until out_o is free.
// Reset clears the velocity to zero, loads the register reset values and
// empties the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module arrive_rate_limited_tracker import artl_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  artl_in_if.sink    in_i,
  artl_out_if.source out_o,
  artl_cfg_if.sink   cfg_i
);

  // Width of the product once the fraction bits are dropped.
  localparam int MAG_W = PROD_W - FRAC_BITS;

  // Sequencer states.
  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_CLAMP_LO = 4'd1;
  localparam logic [3:0] S_CLAMP_HI = 4'd2;
  localparam logic [3:0] S_ERR      = 4'd3;
  localparam logic [3:0] S_ABS      = 4'd4;
  localparam logic [3:0] S_CHECK    = 4'd5;
  localparam logic [3:0] S_MUL_GAIN = 4'd6;
  localparam logic [3:0] S_DESIRED  = 4'd7;
  localparam logic [3:0] S_STEER    = 4'd8;
  localparam logic [3:0] S_FORCE    = 4'd9;
  localparam logic [3:0] S_VEL      = 4'd10;
  localparam logic [3:0] S_MUL_TIME = 4'd11;
  localparam logic [3:0] S_ADD      = 4'd12;
  localparam logic [3:0] S_SAT      = 4'd13;
  localparam logic [3:0] S_DONE     = 4'd14;

  cfg_t cfg;

  logic [3:0] state_q, state_d;

  // Step operands and intermediate results.
  logic signed [VAL_W-1:0]   cur_q;
  logic signed [VAL_W-1:0]   tgt_q;
  logic [TIME_W-1:0]         time_q;
  logic signed [VAL_W:0]     err_q;
  logic [VAL_W-1:0]          dist_q;
  logic [VAL_W-1:0]          speed_q;
  logic signed [VAL_W-1:0]   des_q;
  logic signed [VAL_W:0]     steer_q;
  logic signed [PROD_W-1:0]  sum_q;
  logic [VAL_W-1:0]          res_value_q;
  logic                      res_stopped_q;

  // Stored velocity (the only state carried from step to step).
  logic signed [VAL_W-1:0]   vel_q;

  // Output register.
  logic                      out_valid_q;
  logic signed [VAL_W-1:0]   out_value_q;
  logic                      out_stopped_q;

  // Multiplier hookup.
  logic                      mul_start;
  logic signed [VAL_W-1:0]   mul_a;
  logic [GAIN_W-1:0]         mul_b;
  logic                      mul_busy;
  logic                      mul_done;
  logic signed [PROD_W-1:0]  mul_p;

  // Datapath terms.
  logic signed [VAL_W:0]     err_c;
  logic [VAL_W:0]            err_neg_c;
  logic [VAL_W-1:0]          dist_c;
  logic [VAL_W:0]            vel_neg_c;
  logic [VAL_W-1:0]          speed_c;
  logic                      stop_c;
  logic [DIST_W-1:0]         lim_c;
  logic [MAG_W-1:0]          mag_c;
  logic [VAL_W-1:0]          mag_sat_c;
  logic signed [VAL_W:0]     force_pos_c;
  logic signed [VAL_W:0]     force_neg_c;
  logic [VAL_W:0]            vel_sum_c;
  logic signed [PROD_W-1:0]  prod_sh_c;
  logic [VAL_W-1:0]          sat_c;
  logic                      out_free;

  artl_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  artl_mul u_mul (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (mul_start),
    .a_i       (mul_a),
    .b_i       (mul_b),
    .busy_o    (mul_busy),
    .done_o    (mul_done),
    .product_o (mul_p)
  );

  // Error, distance and speed. Distance fits 32 bits unsigned, speed too.
  assign err_c     = $signed({tgt_q[VAL_W-1], tgt_q}) - $signed({cur_q[VAL_W-1], cur_q});
  assign err_neg_c = -err_q;
  assign dist_c    = err_q[VAL_W] ? err_neg_c[VAL_W-1:0] : err_q[VAL_W-1:0];
  assign vel_neg_c = -{vel_q[VAL_W-1], vel_q};
  assign speed_c   = vel_q[VAL_W-1] ? vel_neg_c[VAL_W-1:0] : vel_q;

  // The stop rule needs both the speed and the distance inside their limits.
  assign stop_c = (speed_q <= {1'b0, cfg.stop_speed}) &&
                  (dist_q <= {1'b0, cfg.stop_distance});
  assign lim_c  = (dist_q < {1'b0, cfg.slow_distance}) ? dist_q[DIST_W-1:0]
                                                       : cfg.slow_distance;

  // The magnitude product is truncated, then saturated so that the signed
  // desired velocity stays in 32 bits (one more step of room when negative).
  assign mag_c = mul_p[PROD_W-1:FRAC_BITS];
  always_comb begin
    if (err_q[VAL_W]) begin
      mag_sat_c = (mag_c > MAG_W'(32'h8000_0000)) ? 32'h8000_0000 : mag_c[VAL_W-1:0];
    end else begin
      mag_sat_c = (mag_c > MAG_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : mag_c[VAL_W-1:0];
    end
  end

  assign force_pos_c = $signed({2'b00, cfg.max_force});
  assign force_neg_c = -force_pos_c;
  assign vel_sum_c   = {vel_q[VAL_W-1], vel_q} + steer_q;

  // Arithmetic shift rounds the position step toward minus infinity.
  assign prod_sh_c = mul_p >>> FRAC_BITS;

  // Saturate the 56-bit sum back to 32 bits signed.
  always_comb begin
    if ((&sum_q[PROD_W-1:VAL_W-1]) || !(|sum_q[PROD_W-1:VAL_W-1])) begin
      sat_c = sum_q[VAL_W-1:0];
    end else if (sum_q[PROD_W-1]) begin
      sat_c = 32'h8000_0000;
    end else begin
      sat_c = 32'h7FFF_FFFF;
    end
  end

  // The multiplier is loaded twice per step, unless the stop rule fires: distance
  // times gain after the stop check, and the new velocity times elapsed time as it is formed.
  assign mul_start = ((state_q == S_CHECK) && !stop_c) || (state_q == S_VEL);
  assign mul_a     = (state_q == S_CHECK) ? $signed({1'b0, lim_c})
                                          : $signed(vel_sum_c[VAL_W-1:0]);
  assign mul_b     = (state_q == S_CHECK) ? cfg.approach_gain : GAIN_W'(time_q);

  assign out_free  = !out_valid_q || out_o.ready;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:     if (in_i.valid) state_d = S_CLAMP_LO;
      S_CLAMP_LO: state_d = S_CLAMP_HI;
      S_CLAMP_HI: state_d = S_ERR;
      S_ERR:      state_d = S_ABS;
      S_ABS:      state_d = S_CHECK;
      S_CHECK:    state_d = stop_c ? S_DONE : S_MUL_GAIN;
      S_MUL_GAIN: if (mul_done) state_d = S_DESIRED;
      S_DESIRED:  state_d = S_STEER;
      S_STEER:    state_d = S_FORCE;
      S_FORCE:    state_d = S_VEL;
      S_VEL:      state_d = S_MUL_TIME;
      S_MUL_TIME: if (mul_done) state_d = S_ADD;
      S_ADD:      state_d = S_SAT;
      S_SAT:      state_d = S_DONE;
      S_DONE:     if (out_free) state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      vel_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CHECK && stop_c) begin
        vel_q <= '0;
      end else if (state_q == S_VEL) begin
        vel_q <= $signed(vel_sum_c[VAL_W-1:0]);
      end
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          cur_q  <= in_i.current_value;
          tgt_q  <= in_i.target_value;
          time_q <= in_i.elapsed_time;
        end
      end
      S_CLAMP_LO: begin
        if (tgt_q < cfg.min_target) tgt_q <= cfg.min_target;
      end
      S_CLAMP_HI: begin
        // Applied second, so the upper bound wins in an inverted window.
        if (tgt_q > cfg.max_target) tgt_q <= cfg.max_target;
      end
      S_ERR: begin
        err_q <= err_c;
      end
      S_ABS: begin
        dist_q  <= dist_c;
        speed_q <= speed_c;
      end
      S_CHECK: begin
        if (stop_c) begin
          res_value_q   <= tgt_q;
          res_stopped_q <= 1'b1;
        end
      end
      S_DESIRED: begin
        des_q <= err_q[VAL_W] ? $signed(-mag_sat_c) : $signed(mag_sat_c);
      end
      S_STEER: begin
        steer_q <= $signed({des_q[VAL_W-1], des_q}) - $signed({vel_q[VAL_W-1], vel_q});
      end
      S_FORCE: begin
        if (steer_q > force_pos_c) begin
          steer_q <= force_pos_c;
        end else if (steer_q < force_neg_c) begin
          steer_q <= force_neg_c;
        end
      end
      S_ADD: begin
        sum_q <= $signed({{(PROD_W - VAL_W){cur_q[VAL_W-1]}}, cur_q}) + prod_sh_c;
      end
      S_SAT: begin
        res_value_q   <= sat_c;
        res_stopped_q <= 1'b0;
      end
      S_DONE: begin
        if (out_free) begin
          out_value_q   <= res_value_q;
          out_stopped_q <= res_stopped_q;
        end
      end
      default: begin
        // The remaining states (the product waits and the velocity update) write nothing here.
      end
    endcase
  end

  assign in_i.ready      = (state_q == S_IDLE);
  assign out_o.valid     = out_valid_q;
  assign out_o.new_value = out_value_q;
  assign out_o.stopped   = out_stopped_q;

  // An accepted step always starts with the target clamp.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> (state_q == S_CLAMP_LO))
    else $error("accepted step did not enter the clamp stage");

  // The sequencer waits on a product only while the multiplier is running.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MUL_GAIN || state_q == S_MUL_TIME) |-> mul_busy)
    else $error("waiting on a product with the multiplier idle");

  // A completion pulse from the multiplier is only seen in a wait state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> (state_q == S_MUL_GAIN || state_q == S_MUL_TIME))
    else $error("multiplier finished outside a wait state");

  // Velocity changes only at the stop check or at the velocity update.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(vel_q) |-> ($past(state_q) == S_CHECK || $past(state_q) == S_VEL))
    else $error("velocity changed outside its update points");

  // When the stop rule fires the velocity is cleared.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CHECK && stop_c) |=> (vel_q == '0))
    else $error("velocity not cleared by the stop rule");

endmodule

`default_nettype wire

/* rtl/artl_cfg.sv */
// ----------------------------------------------------------------------------
// artl_cfg: configuration registers
// Takes register writes from the configuration channel and presents the
// register set as one bundle.
// ----------------------------------------------------------------------------
`default_nettype none

module artl_cfg import artl_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  artl_cfg_if.sink   cfg_i,
  output cfg_t       cfg_o
);

  cfg_t regs_q;

  assign cfg_i.ready = 1'b1;
  assign cfg_o       = regs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q.min_target    <= RST_MIN_TARGET;
      regs_q.max_target    <= RST_MAX_TARGET;
      regs_q.stop_speed    <= RST_STOP_SPEED;
      regs_q.stop_distance <= RST_STOP_DISTANCE;
      regs_q.slow_distance <= RST_SLOW_DISTANCE;
      regs_q.approach_gain <= RST_APPROACH_GAIN;
      regs_q.max_force     <= RST_MAX_FORCE;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_MIN_TARGET:    regs_q.min_target    <= cfg_i.data;
        REG_MAX_TARGET:    regs_q.max_target    <= cfg_i.data;
        REG_STOP_SPEED:    regs_q.stop_speed    <= cfg_i.data[DIST_W-1:0];
        REG_STOP_DISTANCE: regs_q.stop_distance <= cfg_i.data[DIST_W-1:0];
        REG_SLOW_DISTANCE: regs_q.slow_distance <= cfg_i.data[DIST_W-1:0];
        REG_APPROACH_GAIN: regs_q.approach_gain <= cfg_i.data[GAIN_W-1:0];
        REG_MAX_FORCE:     regs_q.max_force     <= cfg_i.data[DIST_W-1:0];
        default: begin
          // Writes to unused indexes are dropped.
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/artl_mul.sv */
// ----------------------------------------------------------------------------
// artl_mul: bit-serial multiplier
// Signed multiplicand times unsigned multiplier, one multiplier bit per
// cycle, by shift and add into a right-shifting product register.
// ----------------------------------------------------------------------------
`default_nettype none

module artl_mul import artl_pkg::*; (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  input  wire logic signed [VAL_W-1:0]  a_i,
  input  wire logic [GAIN_W-1:0]        b_i,
  output logic                          busy_o,
  output logic                          done_o,
  output logic signed [PROD_W-1:0]      product_o
);

  localparam int CNT_W = $clog2(GAIN_W);

  logic                     busy_q;
  logic [CNT_W-1:0]         cnt_q;
  logic signed [VAL_W-1:0]  a_q;
  logic [PROD_W-1:0]        p_q;
  logic [VAL_W:0]           acc;

  // The upper half accumulates the multiplicand when the bit shifted out is set.
  always_comb begin
    acc = {p_q[PROD_W-1], p_q[PROD_W-1:GAIN_W]};
    if (p_q[0]) begin
      acc = acc + {a_q[VAL_W-1], a_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNT_W'(GAIN_W - 1);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
      p_q <= {{VAL_W{1'b0}}, b_i};
    end else if (busy_q) begin
      p_q <= {acc, p_q[GAIN_W-1:1]};
    end
  end

  assign busy_o    = busy_q;
  assign done_o    = busy_q && (cnt_q == '0);
  assign product_o = $signed(p_q);

endmodule

`default_nettype wire
